>>> design/assert_macros.svh
// Assertion macros shared by the RTL. Each use states one property on its own line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at each rising edge, skipped while reset is high.
`define ASSERT_SYNC(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed in cal block");

// Check prop at each rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed in cal block");

`else

`define ASSERT_SYNC(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> design/cal_pkg.sv
`timescale 1ns / 1ps

package cal_pkg;

  localparam logic       CMD_READ  = 1'b0;
  localparam logic       CMD_WRITE = 1'b1;

  localparam logic [11:0] SEL_MASK  = 12'h103;
  localparam logic [11:0] SEL_ACCUM = 12'h100;
  localparam logic [11:0] SEL_INV   = 12'h101;
  localparam logic [11:0] SEL_STAGE = 12'h102;
  localparam logic [11:0] SEL_MODE  = 12'h103;

  typedef struct packed {
    logic        command;
    logic [3:0]  bank;
    logic [11:0] offset;
    logic [7:0]  write_data;
    logic [7:0]  open_bus;
  } access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [4:0] output_latch;
    logic       flag_x;
    logic       flag_y;
  } result_t;

endpackage

>>> design/cal_in_stage.sv
`timescale 1ns / 1ps

module cal_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cal_pkg::access_t acc_in,
  input  logic             advance,
  output logic             valid,
  output cal_pkg::access_t acc
);
  import cal_pkg::*;

  // Take a new transaction when nothing is held or when the held one leaves in this cycle.
  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      acc <= acc_in;
    end
  end

endmodule

>>> design/cal_latch_regs.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cal_latch_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  cal_pkg::access_t acc,
  output cal_pkg::result_t res
);
  import cal_pkg::*;

  logic       increase_mode, increase_mode_next;
  logic [4:0] output_bits, output_bits_next;
  logic       invert_flag, invert_flag_next;
  logic [2:0] staging_bits, staging_bits_next;
  logic [3:0] accum, accum_next;
  logic [4:0] inverter_bits, inverter_bits_next;
  logic       x_flag, x_flag_next;
  logic       y_flag, y_flag_next;
  logic [7:0] rd;
  logic [11:0] sel;
  logic [4:0] hi;
  logic       wr_fire;
  logic       rd_miss;

  assign sel = acc.offset & SEL_MASK;
  assign hi  = inverter_bits ^ {5{invert_flag}};

  always_comb begin
    increase_mode_next = increase_mode;
    output_bits_next   = output_bits;
    invert_flag_next   = invert_flag;
    staging_bits_next  = staging_bits;
    accum_next         = accum;
    inverter_bits_next = inverter_bits;
    x_flag_next        = x_flag;
    y_flag_next        = y_flag;
    rd                 = 8'h00;
    if (acc.command == CMD_READ) begin
      rd = acc.open_bus;
      if (sel == SEL_ACCUM) begin
        rd          = {hi, accum[2:0]};
        y_flag_next = x_flag | hi[1];
      end
    end else begin
      if (acc.bank[3]) begin
        // capture: skip offset decode
        output_bits_next = {inverter_bits[0], accum};
      end else begin
        unique case (sel)
          SEL_ACCUM: begin
            if (increase_mode) begin
              accum_next = accum + 4'd1;
            end else begin
              accum_next = {accum[3], staging_bits ^ {3{invert_flag}}};
            end
          end
          SEL_INV: begin
            invert_flag_next = acc.write_data[0];
          end
          SEL_STAGE: begin
            staging_bits_next  = acc.write_data[2:0];
            inverter_bits_next = acc.write_data[7:3];
          end
          SEL_MODE: begin
            increase_mode_next = acc.write_data[0];
          end
          default: begin
          end
        endcase
      end
      x_flag_next = !invert_flag_next;
      y_flag_next = x_flag_next | acc.write_data[4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      increase_mode <= 1'b0;
      output_bits   <= 5'd0;
      invert_flag   <= 1'b0;
      staging_bits  <= 3'd0;
      accum         <= 4'd0;
      inverter_bits <= 5'd0;
      x_flag        <= 1'b0;
      y_flag        <= 1'b0;
    end else if (fire) begin
      increase_mode <= increase_mode_next;
      output_bits   <= output_bits_next;
      invert_flag   <= invert_flag_next;
      staging_bits  <= staging_bits_next;
      accum         <= accum_next;
      inverter_bits <= inverter_bits_next;
      x_flag        <= x_flag_next;
      y_flag        <= y_flag_next;
    end
  end

  assign res.read_data    = rd;
  assign res.output_latch = output_bits_next;
  assign res.flag_x       = x_flag_next;
  assign res.flag_y       = y_flag_next;

  assign wr_fire = fire && (acc.command == CMD_WRITE);
  assign rd_miss = fire && (acc.command == CMD_READ) && (sel != SEL_ACCUM);

  `ASSERT_SYNC(a_x_after_write, clk, rst, wr_fire |=> (x_flag == !invert_flag))
  `ASSERT_SYNC(a_hold_accum, clk, rst, !fire |=> ($stable(accum) && $stable(output_bits)))
  `ASSERT_SYNC(a_hold_flags, clk, rst, !fire |=> ($stable(y_flag) && $stable(x_flag)))
  `ASSERT_SYNC(a_undecoded_read, clk, rst, rd_miss |=> ($stable(y_flag) && $stable(x_flag)))
  `ASSERT_ALWAYS(a_reset_clear, clk, rst |=> (accum == 4'd0 && output_bits == 5'd0))

endmodule

>>> design/cal_out_stage.sv
`timescale 1ns / 1ps

module cal_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cal_pkg::result_t res_in,
  output logic             out_valid,
  input  logic             out_ready,
  output cal_pkg::result_t res
);
  import cal_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

>>> design/cartridge_accumulator_latch_core.sv
`timescale 1ns / 1ps

// Cartridge protection latch with a 4-bit accumulator. Each input transaction is one
// bus access and yields exactly one result transaction, in order. An access passes an
// input register, then the decode and register update, then a result register, so its
// result is offered from the result register; with out_ready held high one access is
// taken every cycle. The accumulator, flags and latch are all updated in that register
// update, which keeps the rate at one access per clock while the output does not stall.
module cartridge_accumulator_latch_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [3:0]  bank,
  input  logic [11:0] offset,
  input  logic [7:0]  write_data,
  input  logic [7:0]  open_bus,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [4:0]  output_latch,
  output logic        flag_x,
  output logic        flag_y
);
  import cal_pkg::*;

  access_t acc_in;
  access_t acc;
  result_t res_comb;
  result_t res;
  logic    s1_valid;
  logic    advance;

  assign acc_in.command    = command;
  assign acc_in.bank       = bank;
  assign acc_in.offset     = offset;
  assign acc_in.write_data = write_data;
  assign acc_in.open_bus   = open_bus;

  // advance when an access is held and the result register is free or drains this cycle
  assign advance = s1_valid && (!out_valid || out_ready);

  cal_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .acc_in   (acc_in),
    .advance  (advance),
    .valid    (s1_valid),
    .acc      (acc)
  );

  cal_latch_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .acc  (acc),
    .res  (res_comb)
  );

  cal_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (res_comb),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign read_data    = res.read_data;
  assign output_latch = res.output_latch;
  assign flag_x       = res.flag_x;
  assign flag_y       = res.flag_y;

endmodule

>>> tb/tb_cartridge_accumulator_latch_core.sv
`timescale 1ns / 1ps

module tb_cartridge_accumulator_latch_core;
  import cal_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = CMD_READ;
  logic [3:0]  bank = '0;
  logic [11:0] offset = '0;
  logic [7:0]  write_data = '0;
  logic [7:0]  open_bus = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data;
  logic [4:0]  output_latch;
  logic        flag_x;
  logic        flag_y;

  cartridge_accumulator_latch_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .bank(bank),
    .offset(offset),
    .write_data(write_data),
    .open_bus(open_bus),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .output_latch(output_latch),
    .flag_x(flag_x),
    .flag_y(flag_y)
  );

  always #5 clk = ~clk;

  // Latch state as the predictor sees it
  logic       m_increase = 1'b0;
  logic [4:0] m_out_bits = '0;
  logic       m_invert = 1'b0;
  logic [2:0] m_staging = '0;
  logic [3:0] m_accum = '0;
  logic [4:0] m_inverter = '0;
  logic       m_flag_x = 1'b0;
  logic       m_flag_y = 1'b0;

  result_t latch_expected_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_request = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;
  int fail_count = 0;
  int n_accesses = 0;
  int n_results = 0;
  int n_reads_decoded = 0;
  int n_captures = 0;
  int n_wraps = 0;

  function automatic result_t latch_predict(access_t a);
    result_t r;
    logic [11:0] sel;
    logic [4:0] hi;
    sel = a.offset & SEL_MASK;
    r.read_data = '0;
    if (a.command == CMD_READ) begin
      r.read_data = a.open_bus;
      if (sel == SEL_ACCUM) begin
        hi = m_inverter ^ {5{m_invert}};
        r.read_data = {hi, m_accum[2:0]};
        m_flag_y = m_flag_x | r.read_data[4];
        n_reads_decoded++;
      end
    end else begin
      if (a.bank[3]) begin
        m_out_bits = {m_inverter[0], m_accum};
        n_captures++;
      end else begin
        case (sel)
          SEL_ACCUM: begin
            if (m_increase) begin
              if (m_accum == 4'hF) n_wraps++;
              m_accum = m_accum + 4'd1;
            end else begin
              m_accum = {m_accum[3], m_staging ^ {3{m_invert}}};
            end
          end
          SEL_INV: m_invert = a.write_data[0];
          SEL_STAGE: begin
            m_staging = a.write_data[2:0];
            m_inverter = a.write_data[7:3];
          end
          SEL_MODE: m_increase = a.write_data[0];
          default: ;
        endcase
      end
      m_flag_x = ~m_invert;
      m_flag_y = m_flag_x | a.write_data[4];
    end
    r.output_latch = m_out_bits;
    r.flag_x = m_flag_x;
    r.flag_y = m_flag_y;
    return r;
  endfunction

  // Check results first, then predict from the transaction accepted at this edge
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {read_data, output_latch, flag_x, flag_y};
        n_results++;
        if (latch_expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: rd %02h latch %02h x %0b y %0b",
                     got.read_data, got.output_latch, got.flag_x, got.flag_y);
        end else begin
          want = latch_expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch at result %0d: exp rd %02h latch %02h x %0b y %0b,",
                        " got rd %02h latch %02h x %0b y %0b"},
                       n_results, want.read_data, want.output_latch, want.flag_x,
                       want.flag_y, got.read_data, got.output_latch, got.flag_x,
                       got.flag_y);
          end
        end
      end
      if (in_valid && in_ready) begin
        n_accesses++;
        latch_expected_q.push_back(
          latch_predict({command, bank, offset, write_data, open_bus}));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Entered and left right after a rising edge
  task automatic send_access(input access_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= a.command;
    bank <= a.bank;
    offset <= a.offset;
    write_data <= a.write_data;
    open_bus <= a.open_bus;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_fields(input logic cmd, input logic [3:0] bk, input logic [11:0] off,
                             input logic [7:0] data, input logic [7:0] obus);
    send_access({cmd, bk, off, data, obus});
  endtask

  function automatic access_t random_access();
    access_t a;
    a.offset = 12'($urandom);
    // most accesses land on a decoded register
    if ($urandom_range(3) != 0)
      a.offset = (a.offset & ~SEL_MASK) | SEL_ACCUM | 12'($urandom_range(3));
    a.command = 1'($urandom);
    a.bank = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(7));
    a.write_data = 8'($urandom);
    a.open_bus = 8'($urandom);
    return a;
  endfunction

  task automatic test_register_decode();
    send_fields(CMD_READ, 4'd0, SEL_ACCUM, 8'h00, 8'h5A);
    send_fields(CMD_READ, 4'd15, 12'h000, 8'h00, 8'hFF);
    send_fields(CMD_WRITE, 4'd0, SEL_STAGE, 8'hFF, 8'h00);
    send_fields(CMD_WRITE, 4'd0, SEL_INV, 8'h01, 8'h00);
    send_fields(CMD_READ, 4'd15, 12'hFFC, 8'h00, 8'hA5);
    send_fields(CMD_WRITE, 4'd7, SEL_ACCUM, 8'h00, 8'h00);
    send_fields(CMD_WRITE, 4'd0, SEL_INV, 8'hFE, 8'h00);
    send_fields(CMD_READ, 4'd3, SEL_ACCUM, 8'h00, 8'h00);
  endtask

  task automatic test_accumulator_wrap();
    send_fields(CMD_WRITE, 4'd0, SEL_ACCUM, 8'h00, 8'h00);
    send_fields(CMD_WRITE, 4'd0, 12'hFFF, 8'h01, 8'h00);
    // nine increments from 7 pass 15 and wrap to 0
    repeat (9) send_fields(CMD_WRITE, 4'd0, SEL_ACCUM, 8'h00, 8'h00);
  endtask

  task automatic test_capture_and_flags();
    send_fields(CMD_WRITE, 4'd8, SEL_ACCUM, 8'h00, 8'h00);
    send_fields(CMD_WRITE, 4'd15, 12'hFFF, 8'hEF, 8'h00);
    send_fields(CMD_READ, 4'd0, 12'h001, 8'h00, 8'h00);
    send_fields(CMD_WRITE, 4'd0, 12'h000, 8'h10, 8'hFF);
  endtask

  task automatic random_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_access(random_access());
  endtask

  task automatic test_random_traffic();
    random_phase(130, 0, 0);
    random_phase(130, 71, 0);
    random_phase(130, 0, 71);
    random_phase(130, 8, 8);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request <= 1'b1;
    repeat (60) send_access(random_access());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_register_decode();
    test_accumulator_wrap();
    test_capture_and_flags();
    test_random_traffic();
    test_backpressure();
    in_valid <= 1'b0;
    while (latch_expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d bus accesses, %0d results checked", n_accesses, n_results);
    $display("decoded reads %0d, output captures %0d, accumulator wraps %0d",
             n_reads_decoded, n_captures, n_wraps);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
